// ===== sv/ltsc_pkg.sv =====
// Lamp time switch controller: shared types, codes and time arithmetic.
// Used by every module of the block; no dependencies.
package ltsc_pkg;

  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned MinsPerHour = 60;

  localparam logic [2:0] CMD_MODE  = 3'd0;
  localparam logic [2:0] CMD_UP    = 3'd1;
  localparam logic [2:0] CMD_DOWN  = 3'd2;
  localparam logic [2:0] CMD_DIGIT = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;
  localparam logic [2:0] CMD_CLOCK = 3'd5;

  localparam logic [1:0] MODE_BLANK = 2'd0;
  localparam logic [1:0] MODE_CUR   = 2'd1;
  localparam logic [1:0] MODE_ON    = 2'd2;
  localparam logic [1:0] MODE_OFF   = 2'd3;

  localparam logic [1:0] DIG_NONE  = 2'd0;
  localparam logic [1:0] DIG_HOURS = 2'd1;
  localparam logic [1:0] DIG_TENS  = 2'd2;
  localparam logic [1:0] DIG_MINS  = 2'd3;

  localparam logic [1:0] TGT_CUR = 2'd0;
  localparam logic [1:0] TGT_ON  = 2'd1;
  localparam logic [1:0] TGT_OFF = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [4:0] now_hours;
    logic [5:0] now_minutes;
  } evt_t;

  typedef struct packed {
    logic [1:0] display_mode;
    logic [1:0] edit_digit;
    logic [4:0] shown_hours;
    logic [5:0] shown_minutes;
    logic       lamp_on;
    logic       restart_timeout;
    logic       set_clock;
  } res_t;

  function automatic logic [4:0] hours_wrap(input logic [4:0] h);
    hours_wrap = (h >= 5'(HoursPerDay)) ? h - 5'(HoursPerDay) : h;
  endfunction

  function automatic logic [5:0] minutes_wrap(input logic [5:0] m);
    minutes_wrap = (m >= 6'(MinsPerHour)) ? m - 6'(MinsPerHour) : m;
  endfunction

  function automatic logic [4:0] hours_step(input logic [4:0] h, input logic up);
    if (up) begin
      hours_step = (h == 5'(HoursPerDay - 1)) ? 5'd0 : h + 5'd1;
    end else begin
      hours_step = (h == 5'd0) ? 5'(HoursPerDay - 1) : h - 5'd1;
    end
  endfunction

  // big selects a step of ten minutes, otherwise one
  function automatic logic [5:0] minutes_step(input logic [5:0] m, input logic up,
                                               input logic big);
    logic [6:0] d;
    logic [6:0] s;
    d = big ? 7'd10 : 7'd1;
    if (up) begin
      s = {1'b0, m} + d;
      if (s >= 7'(MinsPerHour)) begin
        s = s - 7'(MinsPerHour);
      end
    end else if ({1'b0, m} < d) begin
      s = {1'b0, m} + 7'(MinsPerHour) - d;
    end else begin
      s = {1'b0, m} - d;
    end
    minutes_step = s[5:0];
  endfunction

endpackage

// ===== sv/ltsc_in_reg.sv =====
// Lamp time switch controller: input register for event transactions.
// Depends on ltsc_pkg.
module ltsc_in_reg import ltsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic evt_valid,
  output logic evt_stall,
  input  evt_t evt,
  input  logic go,
  output logic q_valid,
  output evt_t q
);

  assign evt_stall = q_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!evt_stall) begin
      q_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!evt_stall && evt_valid) begin
      q <= evt;
    end
  end

endmodule

// ===== sv/ltsc_fsm.sv =====
// Lamp time switch controller: settings state, edit and lamp logic.
// One registered update per event; result is combinational. Depends on ltsc_pkg.
module ltsc_fsm import ltsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  evt_t evt,
  output res_t res
);

  logic [1:0] mode, mode_next;
  logic [1:0] digit, digit_next;
  logic [1:0] target, target_next;
  logic       startup, startup_next;
  logic [4:0] on_hours, on_hours_next, off_hours, off_hours_next;
  logic [4:0] cur_hours, cur_hours_next;
  logic [5:0] on_minutes, on_minutes_next, off_minutes, off_minutes_next;
  logic [5:0] cur_minutes, cur_minutes_next;
  logic       lamp, lamp_next;

  logic       editing;
  logic [4:0] sel_h, ed_h;
  logic [5:0] sel_m, ed_m;
  logic       restart, setclk;
  logic [1:0] dig_inc;

  assign editing = (mode == MODE_ON) || (mode == MODE_OFF);
  assign dig_inc = digit + 2'd1;

  always_comb begin
    case (target)
      TGT_ON:  begin sel_h = on_hours;  sel_m = on_minutes;  end
      TGT_OFF: begin sel_h = off_hours; sel_m = off_minutes; end
      default: begin sel_h = cur_hours; sel_m = cur_minutes; end
    endcase
    ed_h = sel_h;
    ed_m = sel_m;
    case (digit)
      DIG_HOURS: ed_h = hours_step(sel_h, evt.cmd == CMD_UP);
      DIG_TENS:  ed_m = minutes_step(sel_m, evt.cmd == CMD_UP, 1'b1);
      DIG_MINS:  ed_m = minutes_step(sel_m, evt.cmd == CMD_UP, 1'b0);
      default: ;
    endcase
  end

  always_comb begin
    mode_next        = mode;
    digit_next       = digit;
    target_next      = target;
    startup_next     = startup;
    on_hours_next    = on_hours;
    on_minutes_next  = on_minutes;
    off_hours_next   = off_hours;
    off_minutes_next = off_minutes;
    cur_hours_next   = cur_hours;
    cur_minutes_next = cur_minutes;
    lamp_next        = lamp;
    restart          = 1'b0;
    setclk           = 1'b0;
    unique case (evt.cmd)
      CMD_MODE: begin
        if (!startup) begin
          unique case (mode)
            MODE_BLANK: begin
              mode_next = MODE_CUR;
              restart   = 1'b1;
            end
            MODE_CUR: begin
              mode_next   = MODE_ON;
              target_next = TGT_ON;
              digit_next  = DIG_HOURS;
            end
            MODE_ON: begin
              mode_next   = MODE_OFF;
              target_next = TGT_OFF;
              digit_next  = DIG_HOURS;
            end
            default: begin
              mode_next   = MODE_CUR;
              target_next = TGT_CUR;
              digit_next  = DIG_NONE;
              restart     = 1'b1;
            end
          endcase
        end
      end
      CMD_UP, CMD_DOWN: begin
        if (editing) begin
          case (target)
            TGT_ON:  begin on_hours_next  = ed_h; on_minutes_next  = ed_m; end
            TGT_OFF: begin off_hours_next = ed_h; off_minutes_next = ed_m; end
            default: begin cur_hours_next = ed_h; cur_minutes_next = ed_m; end
          endcase
        end
      end
      CMD_DIGIT: begin
        if (editing) begin
          digit_next = dig_inc;
          if (dig_inc == DIG_NONE) begin
            mode_next   = MODE_CUR;
            target_next = TGT_CUR;
            if (startup) begin
              startup_next = 1'b0;
              setclk       = 1'b1;
              restart      = 1'b1;
            end
          end
        end
      end
      CMD_TICK: begin
        if (!startup) begin
          if (mode == MODE_CUR) begin
            mode_next = MODE_BLANK;
          end
          if (cur_hours == on_hours && cur_minutes == on_minutes) begin
            lamp_next = 1'b1;
          end else if (cur_hours == off_hours && cur_minutes == off_minutes) begin
            lamp_next = 1'b0;
          end
        end
      end
      CMD_CLOCK: begin
        if (!startup && (mode == MODE_BLANK || mode == MODE_CUR)) begin
          cur_hours_next   = hours_wrap(evt.now_hours);
          cur_minutes_next = minutes_wrap(evt.now_minutes);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.display_mode    = mode_next;
    res.edit_digit      = digit_next;
    res.lamp_on         = lamp_next;
    res.restart_timeout = restart;
    res.set_clock       = setclk;
    case (target_next)
      TGT_ON:  begin res.shown_hours = on_hours_next;  res.shown_minutes = on_minutes_next;  end
      TGT_OFF: begin res.shown_hours = off_hours_next; res.shown_minutes = off_minutes_next; end
      default: begin res.shown_hours = cur_hours_next; res.shown_minutes = cur_minutes_next; end
    endcase
    if (mode_next == MODE_BLANK) begin
      res.shown_hours   = 5'd0;
      res.shown_minutes = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_ON;
      digit       <= DIG_HOURS;
      target      <= TGT_CUR;
      startup     <= 1'b1;
      on_hours    <= 5'd0;
      on_minutes  <= 6'd0;
      off_hours   <= 5'd12;
      off_minutes <= 6'd0;
      cur_hours   <= 5'd0;
      cur_minutes <= 6'd0;
      lamp        <= 1'b0;
    end else if (go) begin
      mode        <= mode_next;
      digit       <= digit_next;
      target      <= target_next;
      startup     <= startup_next;
      on_hours    <= on_hours_next;
      on_minutes  <= on_minutes_next;
      off_hours   <= off_hours_next;
      off_minutes <= off_minutes_next;
      cur_hours   <= cur_hours_next;
      cur_minutes <= cur_minutes_next;
      lamp        <= lamp_next;
    end
  end

  // start-up never re-enters once left
  a_startup_sticky: assert property (@(posedge clk) disable iff (rst)
    !startup |=> !startup) else $error("start-up flag set again");

  // clock strobe only on the transaction that ends start-up
  a_setclk_end: assert property (@(posedge clk) disable iff (rst)
    go && res.set_clock |=> !startup && mode == MODE_CUR && target == TGT_CUR)
    else $error("set_clock without end of start-up");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    cur_hours < 5'd24 && on_hours < 5'd24 && off_hours < 5'd24 &&
    cur_minutes < 6'd60 && on_minutes < 6'd60 && off_minutes < 6'd60)
    else $error("stored time out of range");

  a_startup_mode: assert property (@(posedge clk) disable iff (rst)
    startup |-> mode == MODE_ON && target == TGT_CUR)
    else $error("start-up edits wrong time");

endmodule

// ===== sv/ltsc_out_reg.sv =====
// Lamp time switch controller: result register towards the output channel.
// Depends on ltsc_pkg.
module ltsc_out_reg import ltsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  res_t d,
  output logic go,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  assign go = q_valid && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res <= d;
    end
  end

endmodule

// ===== sv/lamp_time_switch_controller_unit.sv =====
// Lamp time switch controller, top level: input register, settings logic,
// result register, which an accepted event passes in that order. Throughput
// one transaction per cycle unless res_stall holds the output, bounded by the
// single registered state update pass. Synchronous active-high reset: start-up
// editing of the current time in hours, lamp off, no transactions in flight.
module lamp_time_switch_controller_unit import ltsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic evt_valid,
  output logic evt_stall,
  input  evt_t evt,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic go;
  logic q_valid;
  evt_t q;
  res_t d;

  ltsc_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .go        (go),
    .q_valid   (q_valid),
    .q         (q)
  );

  ltsc_fsm u_fsm (
    .clk (clk),
    .rst (rst),
    .go  (go),
    .evt (q),
    .res (d)
  );

  ltsc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .d         (d),
    .go        (go),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
